[src/efa_pkg.sv]
// efa_pkg: shared types and constants for the erf approximation pipeline.
// Holds the pipeline stage record, stage layout and Q30 coefficients.
// No dependencies.
package efa_pkg;

    // Default number of fraction bits of the input argument
    localparam int DEF_INPUT_FRAC_BITS = 12;

    // Q30 scale and rounding constant
    localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
    localparam logic [64:0] Q30_HALF = 65'h2000_0000;

    // Q30 coefficients, rounded from their nine-decimal values
    localparam logic [34:0] C_P  = 35'((64'd327591100 * 64'd1073741824 + 64'd500000000)
                                       / 64'd1000000000);
    localparam logic signed [34:0] C_A1 = 35'((64'd254829592 * 64'd1073741824
                                       + 64'd500000000) / 64'd1000000000);
    localparam logic signed [34:0] C_A2 = -35'((64'd284496736 * 64'd1073741824
                                       + 64'd500000000) / 64'd1000000000);
    localparam logic signed [34:0] C_A3 = 35'((64'd1421413741 * 64'd1073741824
                                       + 64'd500000000) / 64'd1000000000);
    localparam logic signed [34:0] C_A4 = -35'((64'd1453152027 * 64'd1073741824
                                       + 64'd500000000) / 64'd1000000000);
    localparam logic signed [34:0] C_A5 = 35'((64'd1061405429 * 64'd1073741824
                                       + 64'd500000000) / 64'd1000000000);

    // Magnitude (Q16) at and above which the result saturates: 6.0
    localparam logic [31:0] SAT_Q16 = 32'h0006_0000;

    // Pipeline layout
    localparam int DIV_STG  = 31;             // one quotient bit per stage
    localparam int TAY_ORD  = 12;             // Taylor terms, three stages each
    localparam int SQ_CNT   = 6;              // squarings, two stages each
    localparam int HOR_CNT  = 5;              // Horner multiplies, two stages each
    localparam int DIV_BASE = 3;
    localparam int TAY_BASE = DIV_BASE + DIV_STG;
    localparam int SQ_BASE  = TAY_BASE + 3 * TAY_ORD;
    localparam int HOR_BASE = SQ_BASE + 2 * SQ_CNT;
    localparam int FIN_BASE = HOR_BASE + 2 * HOR_CNT;
    localparam int NSTG     = FIN_BASE + 2;

    // One pipeline stage record
    typedef struct packed {
        logic               vld;
        logic               neg;
        logic               sat;
        logic [18:0]        ax;
        logic [37:0]        sq;
        logic [31:0]        d;
        logic [31:0]        rem;
        logic [30:0]        t;
        logic [29:0]        z;
        logic [30:0]        r;
        logic [30:0]        p;
        logic               sgn;
        logic signed [34:0] acc;
        logic [65:0]        prod;
        logic [15:0]        res;
    } t_pipe;

    // Coefficient added after Horner multiply h
    function automatic logic signed [34:0] hor_coef(input int h);
        logic signed [34:0] c;
        case (h)
            0:       c = C_A4;
            1:       c = C_A3;
            2:       c = C_A2;
            3:       c = C_A1;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

[src/error_function_approx_top.sv]
// The o_valid strobe follows an accepted start after it passes every pipeline stage.
// Throughput: one transaction per cycle; busy stays low, results cannot be held off.
// The 94-stage pipeline includes 31 divider stages for t = 1/(1+p|x|),
// 36 Taylor stages and 12 squaring stages for exp(-x^2), 10 Horner stages.
// Reset (synchronous, active low) clears every stage register, valid bits included.
// Depends on efa_pkg.
module error_function_approx_top #(
    parameter int INPUT_FRAC_BITS = efa_pkg::DEF_INPUT_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_x_value,
    output logic               o_valid,
    output logic signed [15:0] o_erf_value
);

    efa_pkg::t_pipe r_pl [efa_pkg::NSTG];
    efa_pkg::t_pipe n_pl [efa_pkg::NSTG];

    assign busy = 1'b0;

    // Input stage: magnitude and move to Q16
    logic [16:0] w_mag;
    logic [31:0] w_ax32;
    assign w_mag = i_x_value[15] ? (17'h10000 - {1'b0, i_x_value}) : {1'b0, i_x_value};

    generate
        if (INPUT_FRAC_BITS <= 16) begin : g_shl
            assign w_ax32 = {15'b0, w_mag} << (16 - INPUT_FRAC_BITS);
        end else begin : g_shr
            assign w_ax32 = {15'b0, w_mag} >> (INPUT_FRAC_BITS - 16);
        end
    endgenerate

    always_comb begin
        n_pl[0]     = '0;
        n_pl[0].vld = start && !busy;
        n_pl[0].neg = i_x_value[15];
        n_pl[0].sat = w_ax32 >= efa_pkg::SAT_Q16;
        n_pl[0].ax  = w_ax32[18:0];
    end

    // p*|x| and x^2
    always_comb begin
        n_pl[1]      = r_pl[0];
        n_pl[1].prod = 66'(efa_pkg::C_P) * 66'(r_pl[0].ax);
        n_pl[1].sq   = 38'(r_pl[0].ax) * 38'(r_pl[0].ax);
    end

    // Denominator and exp argument z = x^2/64 in Q30
    always_comb begin
        n_pl[2]     = r_pl[1];
        n_pl[2].d   = 32'({1'b0, efa_pkg::Q30_ONE}
                      + 32'((r_pl[1].prod[48:0] + 49'd32768) >> 16));
        n_pl[2].z   = 30'((39'(r_pl[1].sq) + 39'd128) >> 8);
        n_pl[2].rem = 32'h2000_0000;
        n_pl[2].t   = '0;
    end

    generate
        // Restoring divider: t = round(2^60 / d), one quotient bit per stage
        for (genvar j = 0; j < efa_pkg::DIV_STG; j++) begin : g_div
            localparam int I = efa_pkg::DIV_BASE + j;
            logic [32:0] rem2;
            logic        ge;
            assign rem2 = {r_pl[I-1].rem, r_pl[I-1].d[31-j]};
            assign ge   = rem2 >= {1'b0, r_pl[I-1].d};
            always_comb begin
                n_pl[I]     = r_pl[I-1];
                n_pl[I].rem = ge ? 32'(rem2 - {1'b0, r_pl[I-1].d}) : rem2[31:0];
                n_pl[I].t   = {r_pl[I-1].t[29:0], ge};
            end
        end

        // Taylor series of exp(-z), Horner form, k from 12 down to 1
        for (genvar s = 0; s < efa_pkg::TAY_ORD; s++) begin : g_tay
            localparam int IA = efa_pkg::TAY_BASE + 3 * s;
            localparam int K  = efa_pkg::TAY_ORD - s;
            localparam logic [34:0] RCP = 35'((64'd1 << 34) / K);
            logic [30:0] r_in;
            logic [30:0] pr;
            logic [30:0] q0;
            logic [30:0] rm;
            logic [30:0] qk;
            assign r_in = (s == 0) ? efa_pkg::Q30_ONE : r_pl[IA-1].r;
            assign pr   = 31'((r_pl[IA].prod[64:0] + efa_pkg::Q30_HALF) >> 30);
            assign q0   = 31'(r_pl[IA+1].prod >> 34);
            assign rm   = r_pl[IA+1].p - 31'(q0 * 31'(K));
            assign qk   = (rm >= 31'(K)) ? q0 + 31'd1 : q0;
            // z * r
            always_comb begin
                n_pl[IA]      = r_pl[IA-1];
                n_pl[IA].prod = 66'(r_pl[IA-1].z) * 66'(r_in);
            end
            // round, then multiply by the reciprocal of k
            always_comb begin
                n_pl[IA+1]      = r_pl[IA];
                n_pl[IA+1].p    = pr;
                n_pl[IA+1].prod = 66'(pr) * 66'(RCP);
            end
            // correct the quotient estimate, r = 1 - p/k
            always_comb begin
                n_pl[IA+2]   = r_pl[IA+1];
                n_pl[IA+2].r = efa_pkg::Q30_ONE - qk;
            end
        end

        // Six squarings turn exp(-x^2/64) into exp(-x^2)
        for (genvar s = 0; s < efa_pkg::SQ_CNT; s++) begin : g_sq
            localparam int IA = efa_pkg::SQ_BASE + 2 * s;
            always_comb begin
                n_pl[IA]      = r_pl[IA-1];
                n_pl[IA].prod = 66'(r_pl[IA-1].r) * 66'(r_pl[IA-1].r);
            end
            always_comb begin
                n_pl[IA+1]   = r_pl[IA];
                n_pl[IA+1].r = 31'((r_pl[IA].prod[64:0] + efa_pkg::Q30_HALF) >> 30);
            end
        end

        // Horner polynomial in t, sign-magnitude rounding
        for (genvar h = 0; h < efa_pkg::HOR_CNT; h++) begin : g_hor
            localparam int IA = efa_pkg::HOR_BASE + 2 * h;
            logic signed [34:0] a_in;
            logic [33:0]        m;
            logic [33:0]        mr;
            logic signed [34:0] sres;
            assign a_in = (h == 0) ? efa_pkg::C_A5 : r_pl[IA-1].acc;
            assign m    = a_in[34] ? 34'(-a_in) : 34'(a_in);
            assign mr   = 34'((r_pl[IA].prod[64:0] + efa_pkg::Q30_HALF) >> 30);
            assign sres = r_pl[IA].sgn ? -$signed({1'b0, mr}) : $signed({1'b0, mr});
            always_comb begin
                n_pl[IA]      = r_pl[IA-1];
                n_pl[IA].sgn  = a_in[34];
                n_pl[IA].prod = 66'(m) * 66'(r_pl[IA-1].t);
            end
            always_comb begin
                n_pl[IA+1]     = r_pl[IA];
                n_pl[IA+1].acc = sres + efa_pkg::hor_coef(h);
            end
        end
    endgenerate

    // Final: y = 1 - poly*e, clamp, round to Q1.15, restore sign
    localparam int FA = efa_pkg::FIN_BASE;
    logic [33:0]        f_m;
    logic [33:0]        f_mr;
    logic signed [35:0] f_v;
    logic signed [36:0] f_y;
    logic [30:0]        f_yc;
    logic [15:0]        f_q;
    logic [15:0]        f_qs;

    assign f_m  = r_pl[FA-1].acc[34] ? 34'(-r_pl[FA-1].acc) : 34'(r_pl[FA-1].acc);
    assign f_mr = 34'((r_pl[FA].prod[64:0] + efa_pkg::Q30_HALF) >> 30);
    assign f_v  = r_pl[FA].sgn ? -$signed({2'b0, f_mr}) : $signed({2'b0, f_mr});
    assign f_y  = $signed({6'b0, efa_pkg::Q30_ONE}) - 37'(f_v);

    always_comb begin
        if (f_y < 0) begin
            f_yc = '0;
        end else if (f_y > $signed({6'b0, efa_pkg::Q30_ONE})) begin
            f_yc = efa_pkg::Q30_ONE;
        end else begin
            f_yc = f_y[30:0];
        end
        f_q = 16'((32'(f_yc) + 32'd16384) >> 15);
        if (f_q > 16'd32767 || r_pl[FA].sat) begin
            f_qs = 16'd32767;
        end else begin
            f_qs = f_q;
        end
    end

    always_comb begin
        n_pl[FA]      = r_pl[FA-1];
        n_pl[FA].sgn  = r_pl[FA-1].acc[34];
        n_pl[FA].prod = 66'(f_m) * 66'(r_pl[FA-1].r);
    end

    always_comb begin
        n_pl[FA+1]     = r_pl[FA];
        n_pl[FA+1].res = r_pl[FA].neg ? 16'(-f_qs) : f_qs;
    end

    // Pipeline registers; reset clears every stage
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < efa_pkg::NSTG; i++) begin
            if (!i_rst_n) begin
                r_pl[i] <= '0;
            end else begin
                r_pl[i] <= n_pl[i];
            end
        end
    end

    assign o_valid     = r_pl[efa_pkg::NSTG-1].vld;
    assign o_erf_value = r_pl[efa_pkg::NSTG-1].res;

    // Each result strobe follows an accepted start by the full latency
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, efa_pkg::NSTG))
        else $error("result strobe without matching start");

    // Negative arguments never give a positive result
    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(i_x_value[15], efa_pkg::NSTG)
            |-> (o_erf_value[15] || o_erf_value == 16'sd0))
        else $error("sign of result does not follow argument");

    // Output stays within plus or minus 32767
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_erf_value != 16'sh8000)
        else $error("result out of range");

    // Divider quotient never exceeds one
    a_tmax: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pl[efa_pkg::TAY_BASE-1].vld |-> r_pl[efa_pkg::TAY_BASE-1].t <= efa_pkg::Q30_ONE)
        else $error("reciprocal above one");

endmodule

[tb/testbench.sv]
// testbench: checks error_function_approx_top against a fixed-point erf predictor.
// Drives arguments from a queue through start/busy, compares each o_valid strobe.
// Depends on efa_pkg and error_function_approx_top.
module testbench;

    localparam int FRAC_BITS = efa_pkg::DEF_INPUT_FRAC_BITS;
    localparam int LATENCY   = 94;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] i_x_value;
    logic               o_valid;
    logic signed [15:0] o_erf_value;

    logic [15:0] arg_queue[$];
    logic [15:0] erf_expected[$];
    int          idle_pct;
    int          mismatches;

    error_function_approx_top #(.INPUT_FRAC_BITS(FRAC_BITS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_x_value(i_x_value), .o_valid(o_valid), .o_erf_value(o_erf_value)
    );

    // Q30 multiply, magnitude rounded half up, sign restored
    function automatic longint q30_mul(longint a, longint unsigned t);
        longint unsigned m;
        longint unsigned r;
        m = (a < 0) ? longint'(-a) : longint'(a);
        r = (m * t + 64'd536870912) >> 30;
        return (a < 0) ? -longint'(r) : longint'(r);
    endfunction

    // exp(-s) with s in Q32, Taylor series then six squarings
    function automatic longint unsigned exp_neg(longint unsigned s);
        longint unsigned z;
        longint unsigned r;
        longint unsigned p;
        z = (s + 128) >> 8;
        r = 64'd1 << 30;
        for (int k = 12; k >= 1; k--) begin
            p = (z * r + 64'd536870912) >> 30;
            r = (64'd1 << 30) - p / k;
        end
        for (int i = 0; i < 6; i++) begin
            r = (r * r + 64'd536870912) >> 30;
        end
        return r;
    endfunction

    function automatic longint coef_q30(longint unsigned n);
        return longint'((n * (64'd1 << 30) + 64'd500000000) / 64'd1000000000);
    endfunction

    // Expected erf in Q1.15 for one raw argument
    function automatic logic [15:0] predict_erf(logic [15:0] raw);
        longint unsigned mag, ax, d, t, e, q;
        longint acc, y;
        bit neg;
        neg = raw[15];
        mag = neg ? (64'h10000 - raw) : raw;
        if (FRAC_BITS <= 16) ax = mag << (16 - FRAC_BITS);
        else ax = mag >> (FRAC_BITS - 16);
        if (ax >= (64'd6 << 16)) begin
            q = 32767;
        end else begin
            d = (64'd1 << 30) + ((longint'(coef_q30(327591100)) * ax + 32768) >> 16);
            t = ((64'd1 << 60) + (d >> 1)) / d;
            acc = coef_q30(1061405429);
            acc = -coef_q30(1453152027) + q30_mul(acc, t);
            acc = coef_q30(1421413741) + q30_mul(acc, t);
            acc = -coef_q30(284496736) + q30_mul(acc, t);
            acc = coef_q30(254829592) + q30_mul(acc, t);
            acc = q30_mul(acc, t);
            e = exp_neg(ax * ax);
            y = (64'sd1 << 30) - q30_mul(acc, e);
            if (y < 0) y = 0;
            if (y > (64'sd1 << 30)) y = 64'sd1 << 30;
            q = (longint'(y) + 16384) >> 15;
            if (q > 32767) q = 32767;
        end
        if (neg) q = -q;
        return q[15:0];
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Driver: one transaction per accepted start, random gaps per phase
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start     <= 1'b0;
            i_x_value <= '0;
        end else begin
            if (start && !busy) begin
                erf_expected.push_back(predict_erf(i_x_value));
            end
            if ((!start || !busy) && arg_queue.size() > 0
                && $urandom_range(99) >= idle_pct) begin
                start     <= 1'b1;
                i_x_value <= arg_queue.pop_front();
            end else if (!start || !busy) begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: compare each strobe with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (erf_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %0d", o_erf_value);
            end else if (erf_expected[0] !== o_erf_value) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("erf mismatch: expected %0d actual %0d",
                             $signed(erf_expected[0]), o_erf_value);
                void'(erf_expected.pop_front());
            end else begin
                void'(erf_expected.pop_front());
            end
        end
    end

    task automatic run_phase(int pct, int count);
        logic [15:0] v;
        idle_pct = pct;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(3))
                0: v = 16'($urandom);
                1: v = 16'($signed($urandom_range(12288)) * ($urandom_range(1) ? 1 : -1));
                2: v = 16'($signed($urandom_range(400)) - 200);
                default: v = 16'($signed($urandom_range(24576 + 200, 24576 - 200))
                                 * ($urandom_range(1) ? 1 : -1));
            endcase
            arg_queue.push_back(v);
        end
        while (arg_queue.size() > 0 || start) @(posedge i_clk);
    endtask

    initial begin
        idle_pct   = 0;
        i_rst_n    = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Directed: zero, tiny, extremes, saturation edge, minimum input
        arg_queue = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8001,
                      16'h6000, 16'h5FFF, 16'hA000, 16'hA001, 16'h1000, 16'hF000,
                      16'h0800, 16'hF800, 16'h2000, 16'hE000, 16'h5555, 16'hAAAA};
        while (arg_queue.size() > 0 || start) @(posedge i_clk);
        run_phase(0, 400);
        run_phase(81, 350);
        run_phase(0, 350);
        run_phase(34, 350);
        while (erf_expected.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
src/efa_pkg.sv
src/error_function_approx_top.sv
tb/testbench.sv
